[hw/rtl/elt_pkg.sv]
// ----------------------------------------------------------------------------
// elt_pkg: shared types and constants of the endpoint lap timer table
// Entry layout, status codes, reciprocal constants and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package elt_pkg;

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int TIME_W   = 32;
  localparam int EXP_W    = 10;
  localparam int STATUS_W = 2;
  localparam int MIN_W    = 5;
  localparam int SEC_W    = 6;

  localparam logic [EXP_W-1:0] EXPIRY_RESET = 10'd180;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_STARTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LAP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Expiry threshold is (expiry + 1) * 1000 ms, at most 1024000
  localparam int THR_W = 21;
  localparam int MS_PER_SEC = 1000;
  localparam int SEC_PER_MIN = 60;

  // A surviving hit is younger than 1024000 ms, so 20 bits of age suffice
  localparam int DIFF_W = 20;
  localparam int Q1_W   = 10;   // whole seconds, below 1024

  // floor(x / 1000) = (x * ceil(2^30 / 1000)) >> 30 for x below 2^20
  localparam int SEC_RCP_W = 21;
  localparam int SEC_SHIFT = 30;
  localparam logic [SEC_RCP_W-1:0] SEC_RCP = 21'd1073742;
  localparam int PROD1_W = DIFF_W + SEC_RCP_W;

  // floor(s / 60) = (s * ceil(2^16 / 60)) >> 16 for s below 2^10
  localparam int MIN_RCP_W = 11;
  localparam int MIN_SHIFT = 16;
  localparam logic [MIN_RCP_W-1:0] MIN_RCP = 11'd1093;
  localparam int PROD2_W = Q1_W + MIN_RCP_W;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] start_ms;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic sec_mul;
    logic sec_take;
    logic min_mul;
    logic min_take;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic hit;
  } dp_sts_t;

endpackage

[hw/rtl/endpoint_lap_timer_table.sv]
// ----------------------------------------------------------------------------
// endpoint_lap_timer_table: lap timer keyed by client endpoint
// Table of client endpoints with start times; a request either starts a
// timer or reports the lap since the last start.
// ----------------------------------------------------------------------------
// Usage:
//   A request (src_addr, src_port, now_ms) is taken when start is high and
//   busy is low. The table is scanned one entry a cycle through a
//   registered read port: stale entries are dropped and the endpoint is
//   matched. A miss stores the timer in the lowest free slot.
//   A hit is split into seconds and minutes by two reciprocal
//   multiplications, one stage a cycle.
//   A miss or full table goes from the scan straight to finish; a hit
//   passes through the lap split first.
//   Requests are handled one at a time; the scan length and, on a hit,
//   the lap split set the rate. busy drops the cycle that done pulses, so
//   the next request can be taken then.
//   done marks status/lap_minutes/lap_seconds for a single cycle; the
//   receiver takes it then.
//   The expiry register is written through cfg_valid/cfg_data (always
//   ready); the user writes it only while the block is idle (unchecked).
//   Reset clears all valid bits and sets expiry to 180 seconds.
// ----------------------------------------------------------------------------
module endpoint_lap_timer_table #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [elt_pkg::ADDR_W-1:0]    src_addr,
  input  logic [elt_pkg::PORT_W-1:0]    src_port,
  input  logic [elt_pkg::TIME_W-1:0]    now_ms,
  output logic                          done,
  output logic [elt_pkg::STATUS_W-1:0]  status,
  output logic [elt_pkg::MIN_W-1:0]     lap_minutes,
  output logic [elt_pkg::SEC_W-1:0]     lap_seconds,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [elt_pkg::EXP_W-1:0]     cfg_data
);
  import elt_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  elt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  elt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .src_addr    (src_addr),
    .src_port    (src_port),
    .now_ms      (now_ms),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .status      (status),
    .lap_minutes (lap_minutes),
    .lap_seconds (lap_seconds)
  );

endmodule

[hw/rtl/elt_ctrl.sv]
// ----------------------------------------------------------------------------
// elt_ctrl: request sequencer
// Steps one request through table scan, lap division (on a hit) and table update.
// ----------------------------------------------------------------------------
module elt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  elt_pkg::dp_sts_t  sts,
  output elt_pkg::ctl_cmd_t cmd
);
  import elt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_DIV1   = 7'b0001000,
    S_DIVMID = 7'b0010000,
    S_DIV2   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.sec_mul = 1'b1;
          state_next = S_DIV1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV1: begin
        cmd.sec_take = 1'b1;
        state_next = S_DIVMID;
      end
      S_DIVMID: begin
        cmd.min_mul = 1'b1;
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd.min_take = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[hw/rtl/elt_datapath.sv]
// ----------------------------------------------------------------------------
// elt_datapath: entry table, expiry and match logic, lap split
// Entry storage, valid bits, config register and a reciprocal-multiply
// split of the lap from ms into minutes and seconds.
// ----------------------------------------------------------------------------
module elt_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  elt_pkg::ctl_cmd_t             cmd,
  output elt_pkg::dp_sts_t              sts,
  input  logic [elt_pkg::ADDR_W-1:0]    src_addr,
  input  logic [elt_pkg::PORT_W-1:0]    src_port,
  input  logic [elt_pkg::TIME_W-1:0]    now_ms,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [elt_pkg::EXP_W-1:0]     cfg_data,
  output logic                          done,
  output logic [elt_pkg::STATUS_W-1:0]  status,
  output logic [elt_pkg::MIN_W-1:0]     lap_minutes,
  output logic [elt_pkg::SEC_W-1:0]     lap_seconds
);
  import elt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Config
  logic [EXP_W-1:0] expiry;

  // Request latch
  logic [ADDR_W-1:0] addr_q;
  logic [PORT_W-1:0] port_q;
  logic [TIME_W-1:0] now_q;
  logic [THR_W-1:0]  thresh;

  // Table
  entry_t            mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t            rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_more;
  logic [IDX_W-1:0]  eval_idx;
  logic              eval_en;

  // Scan results
  logic              hit;
  logic [DIFF_W-1:0] hit_diff;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  // Lap split
  logic [PROD1_W-1:0] prod1;
  logic [Q1_W-1:0]    secs_q;
  logic [PROD2_W-1:0] prod2;
  logic [MIN_W-1:0]   mins_q;
  logic [Q1_W-1:0]    mins_x60;

  logic [TIME_W-1:0] diff;
  logic              expired;
  logic              live;
  logic              match;
  logic              do_insert;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= EXPIRY_RESET;
    end else if (cfg_valid) begin
      expiry <= cfg_data;
    end
  end

  // Entry evaluation: expiry first, then first match among survivors
  always_comb begin
    diff    = now_q - rd_data.start_ms;
    expired = (diff >= TIME_W'(thresh));
    live    = valid[eval_idx] && !expired;
    match   = live && !hit && (rd_data.addr == addr_q) && (rd_data.port == port_q);
    do_insert = !hit && free_found;
    mins_x60 = Q1_W'(mins_q) * Q1_W'(SEC_PER_MIN);
  end

  assign sts.scan_last = eval_en && (eval_idx == LAST_IDX);
  assign sts.hit       = hit;

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_more    <= 1'b0;
      eval_en    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        rd_more    <= 1'b1;
        eval_en    <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan) begin
        eval_en <= rd_more;
        if (rd_more && (rd_idx == LAST_IDX)) rd_more <= 1'b0;
        if (eval_en) begin
          valid[eval_idx] <= live && !match;
          if (match) hit <= 1'b1;
          if (!live && !free_found) free_found <= 1'b1;
        end
      end
      if (cmd.finish && do_insert) valid[free_idx] <= 1'b1;
    end
  end

  // Table storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.scan && rd_more) begin
      rd_data <= mem[rd_idx];
    end
    if (cmd.finish && do_insert) begin
      mem[free_idx] <= '{addr: addr_q, port: port_q, start_ms: now_q};
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= src_addr;
      port_q <= src_port;
      now_q  <= now_ms;
      thresh <= THR_W'((THR_W'(expiry) + THR_W'(1)) * MS_PER_SEC);
      rd_idx <= '0;
    end else if (cmd.scan) begin
      if (rd_more) begin
        eval_idx <= rd_idx;
        if (rd_idx != LAST_IDX) rd_idx <= rd_idx + IDX_W'(1);
      end
      if (eval_en) begin
        if (match) hit_diff <= diff[DIFF_W-1:0];
        if (!live && !free_found) free_idx <= eval_idx;
      end
    end

    // Reciprocal multiplication, one stage a cycle
    if (cmd.sec_mul)  prod1  <= PROD1_W'(hit_diff) * PROD1_W'(SEC_RCP);
    if (cmd.sec_take) secs_q <= prod1[SEC_SHIFT +: Q1_W];
    if (cmd.min_mul)  prod2  <= PROD2_W'(secs_q) * PROD2_W'(MIN_RCP);
    if (cmd.min_take) mins_q <= prod2[MIN_SHIFT +: MIN_W];

    if (cmd.finish) begin
      if (hit) begin
        status      <= ST_LAP;
        lap_minutes <= mins_q;
        lap_seconds <= SEC_W'(secs_q - mins_x60);
      end else begin
        status      <= free_found ? ST_STARTED : ST_FULL;
        lap_minutes <= '0;
        lap_seconds <= '0;
      end
    end
  end

endmodule
